/* sv/opem_pkg.sv */
package opem_pkg;

  localparam int NUM_SAMPLES = 4;
  localparam int SAMPLE_W    = 24;
  localparam int ENV_W       = 28;
  localparam int PEAK_W      = 24;
  localparam int ATTACK_W    = 16;
  localparam int DECAY_W     = 24;
  localparam int GAIN_W      = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int STEP_W      = $clog2(NUM_SAMPLES);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // Envelope ceiling: 20.0 in Q5.23
  localparam logic [ENV_W-1:0] ENV_CAP = ENV_W'(20 * (1 << 23));

  localparam logic [CFG_IDX_W-1:0] CFG_FAST_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ATTACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_GAIN   = 2'd3;

  localparam logic [ATTACK_W-1:0] FAST_ATTACK_RST  = 16'd1365;
  localparam logic [ATTACK_W-1:0] SLOW_ATTACK_RST  = 16'd5871;
  localparam logic [DECAY_W-1:0]  DECAY_FACTOR_RST = 24'd16776604;
  localparam logic [GAIN_W-1:0]   METER_GAIN_RST   = 16'd32899;

  typedef enum logic [1:0] {
    KIND_SAMPLES = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RESET   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECAY,
    ST_RISE,
    ST_PEAK
  } state_e;

  typedef struct packed {
    logic [ATTACK_W-1:0] fast_attack;
    logic [ATTACK_W-1:0] slow_attack;
    logic [DECAY_W-1:0]  decay_factor;
    logic [GAIN_W-1:0]   meter_gain;
  } cfg_t;

  typedef struct packed {
    kind_e                                   kind;
    logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0]    samples;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

/* sv/opem_front.sv */
module opem_front (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            in_valid_i,
  output logic                                            in_ready_o,
  input  logic [1:0]                                      in_kind_i,
  input  logic [opem_pkg::NUM_SAMPLES*opem_pkg::SAMPLE_W-1:0] in_data_i,
  output opem_pkg::q_head_t                               head_o,
  input  logic                                            pop_i
);
  import opem_pkg::*;

  item_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   count_q, count_d;
  logic                 known, push, pop;
  item_t                item_in;

  // Drop words whose kind means nothing; they never reach the queue
  assign known = (in_kind_i == KIND_SAMPLES) || (in_kind_i == KIND_READ) ||
                 (in_kind_i == KIND_RESET);
  assign in_ready_o = (count_q != Q_CNT_W'(Q_DEPTH));
  assign push = in_valid_i && in_ready_o && known;
  assign pop  = pop_i && (count_q != '0);

  assign item_in.kind    = kind_e'(in_kind_i);
  assign item_in.samples = in_data_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

/* sv/opem_back.sv */
module opem_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  opem_pkg::cfg_t                    cfg_i,
  input  opem_pkg::q_head_t                 head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2*opem_pkg::PEAK_W-1:0]     out_data_o
);
  import opem_pkg::*;

  function automatic logic [SAMPLE_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] raw);
    abs_sample = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  endfunction

  // Pull env up toward v by attack, truncating the product
  function automatic logic [ENV_W-1:0] rise(input logic [ENV_W-1:0]    env,
                                            input logic [SAMPLE_W-1:0] v,
                                            input logic [ATTACK_W-1:0] attack);
    logic [SAMPLE_W-1:0]          diff;
    logic [ATTACK_W+SAMPLE_W-1:0] prod;
    diff = v - env[SAMPLE_W-1:0];
    prod = attack * diff;
    if (ENV_W'(v) > env) begin
      rise = env + ENV_W'(prod[ATTACK_W+SAMPLE_W-1:ATTACK_W]);
    end else begin
      rise = env;
    end
  endfunction

  state_e                               state_q, state_d;
  logic [STEP_W-1:0]                    step_q, step_d;
  logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] samp_q, samp_d;
  logic [ENV_W-1:0]                     fast_q, fast_d, slow_q, slow_d;
  logic [PEAK_W-1:0]                    ipeak_q, ipeak_d;
  logic [PEAK_W-1:0]                    held_env_q, held_env_d, held_smp_q, held_smp_d;
  logic                                 restart_q, restart_d;
  logic                                 out_valid_q, out_valid_d;
  logic [PEAK_W-1:0]                    out_env_q, out_env_d, out_smp_q, out_smp_d;

  logic [ENV_W-1:0]                     fast_clamp, slow_clamp;
  logic [ENV_W+DECAY_W-1:0]             fast_dprod, slow_dprod;
  logic [SAMPLE_W-1:0]                  cur_v;
  logic [ENV_W:0]                       env_sum;
  logic [GAIN_W+ENV_W:0]                gain_prod;
  logic [ENV_W:0]                       cand_full;
  logic [PEAK_W-1:0]                    cand, base_env, base_smp;

  assign fast_clamp = (fast_q > ENV_CAP) ? ENV_CAP : fast_q;
  assign slow_clamp = (slow_q > ENV_CAP) ? ENV_CAP : slow_q;
  assign fast_dprod = fast_clamp * cfg_i.decay_factor;
  assign slow_dprod = slow_clamp * cfg_i.decay_factor;

  assign cur_v = abs_sample(samp_q[step_q]);

  assign env_sum   = {1'b0, fast_q} + {1'b0, slow_q};
  assign gain_prod = cfg_i.meter_gain * env_sum;
  assign cand_full = gain_prod[GAIN_W+ENV_W:GAIN_W];
  assign cand      = (|cand_full[ENV_W:PEAK_W]) ? '1 : cand_full[PEAK_W-1:0];
  assign base_env  = restart_q ? '0 : held_env_q;
  assign base_smp  = restart_q ? '0 : held_smp_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    samp_d      = samp_q;
    fast_d      = fast_q;
    slow_d      = slow_q;
    ipeak_d     = ipeak_q;
    held_env_d  = held_env_q;
    held_smp_d  = held_smp_q;
    restart_d   = restart_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_env_d   = out_env_q;
    out_smp_d   = out_smp_q;
    pop_o       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.item.kind)
            KIND_SAMPLES: begin
              pop_o   = 1'b1;
              samp_d  = head_i.item.samples;
              state_d = ST_DECAY;
            end
            KIND_READ: begin
              // Hold the read until the output register frees up
              if (!out_valid_q || out_ready_i) begin
                pop_o       = 1'b1;
                out_valid_d = 1'b1;
                out_env_d   = held_env_q;
                out_smp_d   = held_smp_q;
                restart_d   = 1'b1;
              end
            end
            KIND_RESET: begin
              pop_o      = 1'b1;
              held_env_d = '0;
              held_smp_d = '0;
              restart_d  = 1'b1;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_DECAY: begin
        fast_d  = fast_dprod[ENV_W+DECAY_W-1:DECAY_W];
        slow_d  = slow_dprod[ENV_W+DECAY_W-1:DECAY_W];
        step_d  = '0;
        ipeak_d = '0;
        state_d = ST_RISE;
      end
      ST_RISE: begin
        fast_d  = rise(fast_q, cur_v, cfg_i.fast_attack);
        slow_d  = rise(slow_q, cur_v, cfg_i.slow_attack);
        ipeak_d = (cur_v > ipeak_q) ? cur_v : ipeak_q;
        step_d  = step_q + 1'b1;
        if (step_q == STEP_W'(NUM_SAMPLES - 1)) begin
          state_d = ST_PEAK;
        end
      end
      ST_PEAK: begin
        held_env_d = (cand > base_env) ? cand : base_env;
        held_smp_d = (ipeak_q > base_smp) ? ipeak_q : base_smp;
        restart_d  = 1'b0;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      fast_q      <= '0;
      slow_q      <= '0;
      held_env_q  <= '0;
      held_smp_q  <= '0;
      restart_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      fast_q      <= fast_d;
      slow_q      <= slow_d;
      held_env_q  <= held_env_d;
      held_smp_q  <= held_smp_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q    <= samp_d;
    ipeak_q   <= ipeak_d;
    out_env_q <= out_env_d;
    out_smp_q <= out_smp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_smp_q, out_env_q};

endmodule

/* sv/oversampled_peak_envelope_meter_unit.sv */
// Oversampled peak and envelope meter.
// Input stream (s_axis): one word per item. tuser carries the kind (sample
// block, read peaks, reset peaks); tdata carries four signed Q1.23 samples
// of a 4x oversampled block. Unused kinds are taken and dropped.
// Output stream (m_axis): one word per read item with the held envelope peak
// and the held absolute sample peak. A read also arms a restart so the next
// sample block starts both peaks from zero.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 fast attack, 1 slow attack, 2 decay factor, 3 meter gain). Write only
// while the meter is idle.
// Flow: a two-word queue sits between the input and the processing
// sequencer. A sample block runs through the sequencer in steps (pop, decay,
// one rise step per sample, peak update); reads and resets take the pop step alone.
// A read shows on m_axis in the cycle after it leaves the queue.
// Reset clears envelopes and peaks, arms the restart and loads the default
// register values. When the receiver stalls, the result holds in the output
// register, the sequencer stalls on the next read and the queue fills up.
module oversampled_peak_envelope_meter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_0, sample_1, sample_2, sample_3
  input  logic [4*opem_pkg::SAMPLE_W-1:0]      s_axis_tdata,
  // kind
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // envelope_peak, sample_peak
  output logic [2*opem_pkg::PEAK_W-1:0]        m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [opem_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [opem_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import opem_pkg::*;

  cfg_t    cfg_q;
  q_head_t head;
  logic    pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_attack  <= FAST_ATTACK_RST;
      cfg_q.slow_attack  <= SLOW_ATTACK_RST;
      cfg_q.decay_factor <= DECAY_FACTOR_RST;
      cfg_q.meter_gain   <= METER_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAST_ATTACK:  cfg_q.fast_attack  <= cfg_wdata_i[ATTACK_W-1:0];
        CFG_SLOW_ATTACK:  cfg_q.slow_attack  <= cfg_wdata_i[ATTACK_W-1:0];
        CFG_DECAY_FACTOR: cfg_q.decay_factor <= cfg_wdata_i[DECAY_W-1:0];
        CFG_METER_GAIN:   cfg_q.meter_gain   <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  opem_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .head_o     (head),
    .pop_i      (pop)
  );

  opem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // The sequencer never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head.valid)
    else $error("pop from empty queue");

  // A full queue always has a word waiting for the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready |-> head.valid)
    else $error("queue full but head empty");

  // A result appears only right after a read leaves the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(m_axis_tvalid) |-> $past(pop && head.item.kind == KIND_READ))
    else $error("result without a read");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import opem_pkg::*;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [31:0] ENV_CEILING = 32'd20 << 23;
  localparam int          SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [23:0] sample_peak;
    logic [23:0] envelope_peak;
  } peak_rpt_t;

  typedef struct {
    logic [1:0]        kind;
    logic [3:0][23:0]  smp;
    int                env_typed;
    int                smp_typed;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // predictor state
  logic [15:0] fast_atk, slow_atk, meter_gain;
  logic [23:0] decay_fac;
  logic [31:0] fast_env, slow_env;
  logic [23:0] held_env_pk, held_smp_pk;
  logic        restart_armed;

  peak_rpt_t peaks_due[$];
  int        mismatches;
  bit        no_idle;

  oversampled_peak_envelope_meter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [31:0] rise_env(logic [31:0] env, logic [31:0] mag,
                                           logic [15:0] atk);
    logic [47:0] prod;
    if (mag > env) begin
      prod = atk * (mag - env);
      env = env + prod[47:16];
    end
    return env;
  endfunction

  function automatic step_row_t step_row(logic [1:0] kind, int s0, int s1, int s2, int s3,
                                         int env_typed, int smp_typed);
    step_row_t row;
    row.kind = kind;
    row.smp[0] = 24'(s0);
    row.smp[1] = 24'(s1);
    row.smp[2] = 24'(s2);
    row.smp[3] = 24'(s3);
    row.env_typed = env_typed;
    row.smp_typed = smp_typed;
    return row;
  endfunction

  function automatic logic [23:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 24'h800000;
        1: return 24'h7FFFFF;
        2: return 24'h000000;
        3: return 24'hFFFFFF;
        default: return 24'h000001;
      endcase
    end
    if (r < 4) return 24'($signed($urandom_range(0, 4095)) - 2048);
    return 24'($urandom);
  endfunction

  // Advance the meter state by one word; queue the report for a read.
  task automatic meter_update(input logic [1:0] kind, input logic [3:0][23:0] smp);
    logic [31:0] fe, se, mag;
    logic [23:0] pk;
    logic [63:0] prod, cand;
    case (kind)
      KIND_READ: begin
        peaks_due.push_back('{sample_peak: held_smp_pk, envelope_peak: held_env_pk});
        restart_armed = 1'b1;
      end
      KIND_RESET: begin
        held_env_pk = '0;
        held_smp_pk = '0;
        restart_armed = 1'b1;
      end
      KIND_SAMPLES: begin
        fe = (fast_env > ENV_CEILING) ? ENV_CEILING : fast_env;
        se = (slow_env > ENV_CEILING) ? ENV_CEILING : slow_env;
        prod = 64'(fe) * 64'(decay_fac);
        fe = prod[55:24];
        prod = 64'(se) * 64'(decay_fac);
        se = prod[55:24];
        pk = '0;
        for (int i = 0; i < 4; i++) begin
          mag = smp[i][23] ? (32'h1000000 - {8'b0, smp[i]}) : {8'b0, smp[i]};
          fe = rise_env(fe, mag, fast_atk);
          se = rise_env(se, mag, slow_atk);
          if (mag > {8'b0, pk}) pk = mag[23:0];
        end
        fast_env = fe;
        slow_env = se;
        cand = (64'(meter_gain) * (64'(fe) + 64'(se))) >> 16;
        if (cand > 64'hFFFFFF) cand = 64'hFFFFFF;
        if (restart_armed) begin
          held_env_pk = '0;
          held_smp_pk = '0;
          restart_armed = 1'b0;
        end
        if (cand[23:0] > held_env_pk) held_env_pk = cand[23:0];
        if (pk > held_smp_pk) held_smp_pk = pk;
      end
      default: ;
    endcase
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_word(input logic [1:0] kind, input logic [3:0][23:0] smp,
                           input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    meter_update(kind, smp);
  endtask

  task automatic settle_meter();
    s_axis_tvalid <= 1'b0;
    wait (peaks_due.size() == 0);
    @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_meter_regs(input logic [15:0] fa, input logic [15:0] sa,
                                 input logic [23:0] df, input logic [15:0] mg);
    logic [23:0] vals[4];
    vals = '{24'(fa), 24'(sa), df, 24'(mg)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    fast_atk   = fa;
    slow_atk   = sa;
    decay_fac  = df;
    meter_gain = mg;
  endtask

  task automatic run_random(input int n_words, input int pause_at);
    logic [1:0]       kind;
    logic [3:0][23:0] smp;
    int unsigned      r;
    int               sent;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 72)      kind = KIND_SAMPLES;
      else if (r < 88) kind = KIND_READ;
      else if (r < 94) kind = KIND_RESET;
      else             kind = KIND_UNUSED;
      for (int i = 0; i < 4; i++) smp[i] = rand_sample();
      send_word(kind, smp, pick_gap());
      if (kind != KIND_UNUSED) sent++;
      // hold the sender until every pending report has drained
      if (sent == pause_at) settle_meter();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      peak_rpt_t want;
      if (peaks_due.size() == 0) begin
        $error("unexpected word on output: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = peaks_due.pop_front();
        if (m_axis_tdata[23:0] !== want.envelope_peak) begin
          $error("envelope_peak expected %0d actual %0d", want.envelope_peak,
                 m_axis_tdata[23:0]);
          mismatches++;
        end
        if (m_axis_tdata[47:24] !== want.sample_peak) begin
          $error("sample_peak expected %0d actual %0d", want.sample_peak,
                 m_axis_tdata[47:24]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 120)) @(negedge clk_i);
      else repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  end

  initial begin
    step_row_t dir_rows [21];
    peak_rpt_t last;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    mismatches    = 0;
    no_idle       = 1'b0;
    fast_atk      = FAST_ATTACK_RST;
    slow_atk      = SLOW_ATTACK_RST;
    decay_fac     = DECAY_FACTOR_RST;
    meter_gain    = METER_GAIN_RST;
    fast_env      = '0;
    slow_env      = '0;
    held_env_pk   = '0;
    held_smp_pk   = '0;
    restart_armed = 1'b1;

    dir_rows = '{
      step_row(KIND_READ,    0, 0, 0, 0, 0, 0),
      step_row(KIND_SAMPLES, 0, 0, 0, 0, -1, -1),
      step_row(KIND_READ,    0, 0, 0, 0, 0, 0),
      step_row(KIND_SAMPLES, -8388608, 8388607, 0, -1, -1, -1),
      step_row(KIND_READ,    0, 0, 0, 0, -1, 8388608),
      step_row(KIND_READ,    0, 0, 0, 0, -1, 8388608),
      step_row(KIND_SAMPLES, 1, -1, 2, -2, -1, -1),
      step_row(KIND_READ,    0, 0, 0, 0, -1, 2),
      step_row(KIND_SAMPLES, 8388607, 8388607, 8388607, 8388607, -1, -1),
      step_row(KIND_RESET,   0, 0, 0, 0, -1, -1),
      step_row(KIND_READ,    0, 0, 0, 0, 0, 0),
      step_row(KIND_UNUSED,  8388607, -8388608, 5, -5, -1, -1),
      step_row(KIND_SAMPLES, 100, 200, 300, 400, -1, -1),
      step_row(KIND_UNUSED,  -8388608, -8388608, -8388608, -8388608, -1, -1),
      step_row(KIND_READ,    0, 0, 0, 0, -1, 400),
      step_row(KIND_SAMPLES, 8388607, -8388607, 8388607, -8388607, -1, -1),
      step_row(KIND_SAMPLES, 5, -5, 3, 0, -1, -1),
      step_row(KIND_READ,    0, 0, 0, 0, -1, 8388607),
      step_row(KIND_RESET,   0, 0, 0, 0, -1, -1),
      step_row(KIND_SAMPLES, 0, 0, 0, 0, -1, -1),
      step_row(KIND_READ,    0, 0, 0, 0, -1, 0)
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].kind, dir_rows[i].smp, pick_gap());
      if (dir_rows[i].kind == KIND_READ) begin
        last = peaks_due.pop_back();
        if (dir_rows[i].env_typed >= 0) last.envelope_peak = 24'(dir_rows[i].env_typed);
        if (dir_rows[i].smp_typed >= 0) last.sample_peak = 24'(dir_rows[i].smp_typed);
        peaks_due.push_back(last);
      end
    end

    settle_meter();
    load_meter_regs(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    run_random(200, -1);

    settle_meter();
    load_meter_regs(16'h0000, 16'h0000, 24'h000000, 16'h0000);
    run_random(120, -1);

    settle_meter();
    load_meter_regs(16'($urandom), 16'($urandom), 24'($urandom), 16'($urandom));
    no_idle = 1'b1;
    run_random(60, -1);
    no_idle = 1'b0;
    run_random(180, 90);

    settle_meter();
    load_meter_regs(FAST_ATTACK_RST, SLOW_ATTACK_RST, DECAY_FACTOR_RST, METER_GAIN_RST);
    run_random(270, -1);

    s_axis_tvalid <= 1'b0;
    wait (peaks_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/opem_pkg.sv
sv/opem_front.sv
sv/opem_back.sv
sv/oversampled_peak_envelope_meter_unit.sv
test/testbench.sv
